// ===== hdl/spiseq_pkg.sv =====
// Shared constants, result types and helpers for the SPI EEPROM access sequencer.
`timescale 1ns / 1ps
`default_nettype none

package spiseq_pkg;

    // Device opcodes and status bits.
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] BUSY_BIT  = 8'h01;
    localparam logic [7:0] DUMMY     = 8'h00;

    // Page geometry; the page offset is taken with % PAGE_BYTES.
    localparam int PAGE_BYTES = 32;
    localparam int PAGE_W     = $clog2(PAGE_BYTES + 1);

    // Input item kinds.
    localparam logic [1:0] KIND_START_READ  = 2'd0;
    localparam logic [1:0] KIND_START_WRITE = 2'd1;
    localparam logic [1:0] KIND_WRITE_DATA  = 2'd2;
    localparam logic [1:0] KIND_SPI_RX      = 2'd3;

    // Most results that one input item can cause.
    localparam int MAX_RES = 4;
    localparam int IDX_W   = $clog2(MAX_RES);

    typedef struct packed {
        logic       is_transfer;
        logic [7:0] mosi_byte;
        logic       keep_selected;
        logic       want_reply;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic       rejected;
    } res_t;

    typedef res_t [MAX_RES-1:0] batch_t;

    // Results of one step and the index of the last one in use.
    typedef struct packed {
        batch_t           batch;
        logic [IDX_W-1:0] last_idx;
    } step_out_t;

    function automatic res_t send_res(input logic [7:0] mosi, input logic keep,
                                      input logic want);
        res_t r;
        r               = '0;
        r.is_transfer   = 1'b1;
        r.mosi_byte     = mosi;
        r.keep_selected = keep;
        r.want_reply    = want;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/spiseq_step.sv =====
// Phase state of the sequencer and the next-state logic for one input item.
`timescale 1ns / 1ps
`default_nettype none

module spiseq_step
    import spiseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] byte_count,
    input  wire logic [7:0]  write_byte,
    input  wire logic [7:0]  miso_byte,
    output step_out_t        step_out
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_READ  = 2'd1;
    localparam logic [1:0] PH_POLL  = 2'd2;
    localparam logic [1:0] PH_WDATA = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [15:0]       cur_address_reg, cur_address_next;
    logic [15:0]       bytes_left_reg, bytes_left_next;
    logic [PAGE_W-1:0] page_left_reg, page_left_next;

    logic [15:0]       bytes_dec;
    logic [PAGE_W-1:0] page_dec;
    logic [PAGE_W-1:0] room_full;
    logic [PAGE_W-1:0] room;
    res_t              rej_res;
    res_t              done_only;

    always_comb
    begin
        bytes_dec = bytes_left_reg - 16'd1;
        page_dec  = page_left_reg - PAGE_W'(1);
        room_full = PAGE_W'(PAGE_BYTES)
                  - PAGE_W'(cur_address_reg % 16'(PAGE_BYTES));
        if (16'(room_full) > bytes_left_reg)
        begin
            room = bytes_left_reg[PAGE_W-1:0];
        end
        else
        begin
            room = room_full;
        end

        rej_res            = '0;
        rej_res.rejected   = 1'b1;
        done_only          = '0;
        done_only.done_res = 1'b1;

        phase_next       = phase_reg;
        cur_address_next = cur_address_reg;
        bytes_left_next  = bytes_left_reg;
        page_left_next   = page_left_reg;
        step_out         = '0;
        step_out.batch[0] = rej_res;

        case (phase_reg)
            PH_IDLE:
            begin
                if (kind == KIND_START_READ)
                begin
                    step_out.batch[0] = send_res(CMD_READ, 1'b1, 1'b0);
                    step_out.batch[1] = send_res(start_address[15:8], 1'b1, 1'b0);
                    step_out.last_idx = IDX_W'(3);
                    if (byte_count == 16'd0)
                    begin
                        // Nothing to read: drop select after the address.
                        step_out.batch[2] = send_res(start_address[7:0], 1'b0, 1'b0);
                        step_out.batch[3] = done_only;
                    end
                    else
                    begin
                        step_out.batch[2] = send_res(start_address[7:0], 1'b1, 1'b0);
                        step_out.batch[3] = send_res(DUMMY, byte_count > 16'd1, 1'b1);
                        bytes_left_next   = byte_count;
                        cur_address_next  = start_address;
                        phase_next        = PH_READ;
                    end
                end
                else if (kind == KIND_START_WRITE)
                begin
                    cur_address_next  = start_address;
                    bytes_left_next   = byte_count;
                    step_out.batch[0] = send_res(CMD_RDSR, 1'b1, 1'b0);
                    step_out.batch[1] = send_res(DUMMY, 1'b0, 1'b1);
                    step_out.last_idx = IDX_W'(1);
                    phase_next        = PH_POLL;
                end
            end
            PH_READ:
            begin
                if (kind == KIND_SPI_RX)
                begin
                    bytes_left_next              = bytes_dec;
                    step_out.batch[0]            = '0;
                    step_out.batch[0].read_valid = 1'b1;
                    step_out.batch[0].read_byte  = miso_byte;
                    if (bytes_dec == 16'd0)
                    begin
                        step_out.batch[0].done_res = 1'b1;
                        phase_next                 = PH_IDLE;
                    end
                    else
                    begin
                        step_out.batch[1] = send_res(DUMMY, bytes_dec > 16'd1, 1'b1);
                        step_out.last_idx = IDX_W'(1);
                    end
                end
            end
            PH_POLL:
            begin
                if (kind == KIND_SPI_RX)
                begin
                    if ((miso_byte & BUSY_BIT) != 8'd0)
                    begin
                        step_out.batch[0] = send_res(CMD_RDSR, 1'b1, 1'b0);
                        step_out.batch[1] = send_res(DUMMY, 1'b0, 1'b1);
                        step_out.last_idx = IDX_W'(1);
                    end
                    else if (bytes_left_reg == 16'd0)
                    begin
                        step_out.batch[0] = done_only;
                        phase_next        = PH_IDLE;
                    end
                    else
                    begin
                        page_left_next    = room;
                        step_out.batch[0] = send_res(CMD_WREN, 1'b0, 1'b0);
                        step_out.batch[1] = send_res(CMD_WRITE, 1'b1, 1'b0);
                        step_out.batch[2] = send_res(cur_address_reg[15:8], 1'b1, 1'b0);
                        step_out.batch[3] = send_res(cur_address_reg[7:0], 1'b1, 1'b0);
                        step_out.last_idx = IDX_W'(3);
                        phase_next        = PH_WDATA;
                    end
                end
            end
            PH_WDATA:
            begin
                if (kind == KIND_WRITE_DATA)
                begin
                    step_out.batch[0] = send_res(write_byte, page_left_reg > PAGE_W'(1),
                                                 1'b0);
                    page_left_next    = page_dec;
                    bytes_left_next   = bytes_dec;
                    cur_address_next  = cur_address_reg + 16'd1;
                    if (page_dec == PAGE_W'(0))
                    begin
                        // Page closed: poll until the write cycle finishes.
                        step_out.batch[1] = send_res(CMD_RDSR, 1'b1, 1'b0);
                        step_out.batch[2] = send_res(DUMMY, 1'b0, 1'b1);
                        step_out.last_idx = IDX_W'(2);
                        phase_next        = PH_POLL;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            cur_address_reg <= '0;
            bytes_left_reg  <= '0;
            page_left_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            cur_address_reg <= cur_address_next;
            bytes_left_reg  <= bytes_left_next;
            page_left_reg   <= page_left_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/spi_eeprom_access_sequencer.sv =====
// Top level of the SPI EEPROM access sequencer: stream ports and result buffering.
`timescale 1ns / 1ps
`default_nettype none

// The sequencer turns read and write requests for a 25xx-style SPI EEPROM with
// 16-bit addresses into a stream of byte transactions for an SPI shifter.
// Each input transaction (a request, a write data byte, or a byte received
// from the device) is decoded and yields one to four result transactions,
// which leave one per cycle on the master side while m_tready is high;
// m_tlast marks the final result of each input transaction. A result with
// is_transfer set asks the shifter to send mosi_byte and to hold chip select
// afterwards when keep_selected is set; when want_reply is set the received
// byte must be fed back as a "received SPI byte" input. Writes poll the
// status register until the busy bit clears, then send WREN as its own
// frame and WRITE with the address, and stream data up to each 32-byte page
// boundary. An input that the current phase does not expect gives a single
// result with rejected set and leaves the state unchanged. Rate: while
// m_tready is high, an input producing one result can be taken every cycle;
// an input producing several results holds the single output port until its
// last result is taken, so the sustained rate is set by the output port at
// one result per cycle. A second result slot lets the next input be taken
// while the current results drain, and s_tready comes straight from a register.
module spi_eeprom_access_sequencer
    import spiseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] start_address, [31:16] byte_count, [39:32] write_byte, [47:40] miso_byte
    input  wire logic [47:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] mosi_byte, [8] keep_selected, [9] want_reply, [17:10] read_byte, [23:18] zero
    output logic [23:0]      m_tdata,
    // [0] is_transfer, [1] read_valid, [2] done_res, [3] rejected
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);

    step_out_t        step_out;
    logic             s_accept;
    logic             out_finish;
    logic             out_free;
    logic             load_from_pend;
    logic             load_from_in;
    res_t             cur_res;

    // Pending slot: results of an accepted input waiting for the output slot.
    logic             pend_valid_reg;
    step_out_t        pend_reg;

    // Output slot: results being handed out, one per cycle while m_tready is high.
    logic             out_valid_reg;
    step_out_t        out_reg;
    logic [IDX_W-1:0] out_idx_reg;

    spiseq_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_accept),
        .kind          (s_tuser),
        .start_address (s_tdata[15:0]),
        .byte_count    (s_tdata[31:16]),
        .write_byte    (s_tdata[39:32]),
        .miso_byte     (s_tdata[47:40]),
        .step_out      (step_out)
    );

    assign s_tready = !pend_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    assign out_finish = out_valid_reg && m_tready && (out_idx_reg == out_reg.last_idx);
    assign out_free   = !out_valid_reg || out_finish;

    // The pending slot always goes first; a new input skips it when it can.
    assign load_from_pend = pend_valid_reg && out_free;
    assign load_from_in   = s_accept && !pend_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_idx_reg    <= '0;
        end
        else
        begin
            if (s_accept && !load_from_in)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (load_from_pend)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (load_from_pend || load_from_in)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= '0;
            end
            else if (out_finish)
            begin
                out_valid_reg <= 1'b0;
                out_idx_reg   <= '0;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_idx_reg <= out_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && !load_from_in)
        begin
            pend_reg <= step_out;
        end

        if (load_from_pend)
        begin
            out_reg <= pend_reg;
        end
        else if (load_from_in)
        begin
            out_reg <= step_out;
        end
    end

    assign cur_res  = out_reg.batch[out_idx_reg];
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_idx_reg == out_reg.last_idx;
    assign m_tdata  = {6'd0, cur_res.read_byte, cur_res.want_reply,
                       cur_res.keep_selected, cur_res.mosi_byte};
    assign m_tuser  = {cur_res.rejected, cur_res.done_res, cur_res.read_valid,
                       cur_res.is_transfer};

endmodule

`default_nettype wire
